/* rtl/tlpq_pkg.sv */
`default_nettype none
package tlpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int VALUE_BITS = 16;
   localparam int THRESH_BITS = 16;
   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic signed [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(60);
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_THRESHOLD = CSR_ADDR_BITS'(0);

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_PUT_HIGH  = 3'd0,
      STATUS_PUT_LOW   = 3'd1,
      STATUS_TOOK_HIGH = 3'd2,
      STATUS_TOOK_LOW  = 3'd3,
      STATUS_FULL      = 3'd4,
      STATUS_EMPTY     = 3'd5
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage
`default_nettype wire

/* rtl/two_level_priority_queue_unit.sv */
// Channel   Handshake                 Payload
// request   start, busy               req_mode, req_value_in
// response  rsp_valid (strobe)        rsp_status, rsp_value_out
// config    psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One transaction per cycle; busy stays low.
// The response appears in the cycle after its request; its value comes from the
// registered read port of the queue memories.
// Synchronous reset empties both queues and loads the threshold with 60.
// The receiver cannot stall; each response is shown for exactly one cycle.
`default_nettype none
module two_level_priority_queue_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_mode,
   input  wire logic [tlpq_pkg::VALUE_BITS-1:0]     req_value_in,
   output logic                                     rsp_valid,
   output logic      [2:0]                          rsp_status,
   output logic      [tlpq_pkg::VALUE_BITS-1:0]     rsp_value_out,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tlpq_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [tlpq_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [tlpq_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                     pready
);
   import tlpq_pkg::*;

   logic [THRESH_BITS-1:0] threshold;
   logic                   accept;
   logic                   is_high;
   fifo_ctl_type           high_ctl, low_ctl;
   fifo_stat_type          high_stat, low_stat;
   logic [VALUE_BITS-1:0]  high_rd, low_rd;

   status_type status_ff, status_in;
   logic       valid_ff, valid_in;
   logic       take_high_ff, take_high_in;
   logic       take_low_ff, take_low_in;

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign is_high = $signed(req_value_in) > $signed(threshold);

   always_comb begin
      high_ctl.push = accept & (req_mode == MODE_INSERT) & is_high & ~high_stat.full;
      low_ctl.push  = accept & (req_mode == MODE_INSERT) & ~is_high & ~low_stat.full;
      high_ctl.pop  = accept & (req_mode == MODE_REMOVE) & ~high_stat.empty;
      low_ctl.pop   = accept & (req_mode == MODE_REMOVE) & high_stat.empty
                      & ~low_stat.empty;
   end

   always_comb begin
      valid_in     = accept;
      take_high_in = high_ctl.pop;
      take_low_in  = low_ctl.pop;
      priority if (req_mode == MODE_INSERT) begin
         if (is_high) begin
            status_in = high_stat.full ? STATUS_FULL : STATUS_PUT_HIGH;
         end else begin
            status_in = low_stat.full ? STATUS_FULL : STATUS_PUT_LOW;
         end
      end else if (!high_stat.empty) begin
         status_in = STATUS_TOOK_HIGH;
      end else if (!low_stat.empty) begin
         status_in = STATUS_TOOK_LOW;
      end else begin
         status_in = STATUS_EMPTY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         take_high_ff <= 1'b0;
         take_low_ff  <= 1'b0;
         status_ff    <= STATUS_EMPTY;
      end else begin
         valid_ff     <= valid_in;
         take_high_ff <= take_high_in;
         take_low_ff  <= take_low_in;
         status_ff    <= status_in;
      end
   end

   always_comb begin
      priority if (take_high_ff) begin
         rsp_value_out = high_rd;
      end else if (take_low_ff) begin
         rsp_value_out = low_rd;
      end else begin
         rsp_value_out = '0;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;

   tlpq_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .threshold(threshold)
   );

   tlpq_fifo u_high (
      .clock  (clock),
      .reset  (reset),
      .ctl    (high_ctl),
      .wr_data(req_value_in),
      .stat   (high_stat),
      .rd_data(high_rd)
   );

   tlpq_fifo u_low (
      .clock  (clock),
      .reset  (reset),
      .ctl    (low_ctl),
      .wr_data(req_value_in),
      .stat   (low_stat),
      .rd_data(low_rd)
   );

endmodule
`default_nettype wire

/* rtl/tlpq_ram.sv */
`default_nettype none
module tlpq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/tlpq_fifo.sv */
`default_nettype none
module tlpq_fifo (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tlpq_pkg::fifo_ctl_type           ctl,
   input  wire logic [tlpq_pkg::VALUE_BITS-1:0]  wr_data,
   output tlpq_pkg::fifo_stat_type               stat,
   output logic      [tlpq_pkg::VALUE_BITS-1:0]  rd_data
);
   import tlpq_pkg::*;

   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS:0]   tail_sum;
   logic [PTR_BITS-1:0] tail;

   always_comb begin
      tail_sum = (CNT_BITS+1)'(head_ff) + (CNT_BITS+1)'(count_ff);
      if (tail_sum >= (CNT_BITS+1)'(QUEUE_DEPTH)) begin
         tail = PTR_BITS'(tail_sum - (CNT_BITS+1)'(QUEUE_DEPTH));
      end else begin
         tail = PTR_BITS'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (ctl.push) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_BITS'(1);
         if (head_ff == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   end

   tlpq_ram #(
      .WIDTH(VALUE_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(tail),
      .wr_data(wr_data),
      .rd_en  (ctl.pop),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

endmodule
`default_nettype wire

/* rtl/tlpq_csr.sv */
`default_nettype none
module tlpq_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tlpq_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [tlpq_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [tlpq_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                     pready,
   output logic      [tlpq_pkg::THRESH_BITS-1:0]    threshold
);
   import tlpq_pkg::*;

   logic [THRESH_BITS-1:0] threshold_ff, threshold_in;
   logic                   wr_hit;

   assign wr_hit = psel & penable & pwrite & (paddr == ADDR_THRESHOLD);

   always_comb begin
      threshold_in = threshold_ff;
      if (wr_hit) begin
         threshold_in = pwdata[THRESH_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == ADDR_THRESHOLD) begin
         prdata = CSR_DATA_BITS'(threshold_ff);
      end
   end

   assign pready    = 1'b1;
   assign threshold = threshold_ff;

endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;
   import tlpq_pkg::*;

   typedef struct packed {
      status_type                status;
      logic [VALUE_BITS-1:0]     value;
   } response_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      req_mode = MODE_INSERT;
   logic [VALUE_BITS-1:0]     req_value_in = '0;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  paddr = ADDR_THRESHOLD;
   logic [CSR_DATA_BITS-1:0]  pwdata = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic [2:0]                rsp_status;
   logic [VALUE_BITS-1:0]     rsp_value_out;
   logic [CSR_DATA_BITS-1:0]  prdata;
   logic                      pready;

   two_level_priority_queue_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value_in  (req_value_in),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [VALUE_BITS-1:0]          high_entries [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0]          low_entries [QUEUE_DEPTH];
   int                             high_head;
   int                             high_count;
   int                             low_head;
   int                             low_count;
   logic signed [THRESH_BITS-1:0]  threshold_copy = THRESH_RESET;
   response_type                   expected_responses [$];
   int                             error_count = 0;
   int                             transaction_count = 0;
   int                             threshold_writes = 0;
   int                             status_seen [6];

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 40) begin
         $display("mismatch at %0t: %s, got %0h, expected %0h", $time, what, got, want);
      end
   endtask

   function automatic response_type predict_response(input logic mode,
                                                     input logic [VALUE_BITS-1:0] value);
      response_type r;
      r.value = '0;
      if (mode == MODE_INSERT) begin
         if ($signed(value) > threshold_copy) begin
            if (high_count == QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               high_entries[(high_head + high_count) % QUEUE_DEPTH] = value;
               high_count++;
               r.status = STATUS_PUT_HIGH;
            end
         end else begin
            if (low_count == QUEUE_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               low_entries[(low_head + low_count) % QUEUE_DEPTH] = value;
               low_count++;
               r.status = STATUS_PUT_LOW;
            end
         end
      end else if (high_count > 0) begin
         r.value = high_entries[high_head];
         high_head = (high_head + 1) % QUEUE_DEPTH;
         high_count--;
         r.status = STATUS_TOOK_HIGH;
      end else if (low_count > 0) begin
         r.value = low_entries[low_head];
         low_head = (low_head + 1) % QUEUE_DEPTH;
         low_count--;
         r.status = STATUS_TOOK_LOW;
      end else begin
         r.status = STATUS_EMPTY;
      end
      return r;
   endfunction

   always @(posedge clock) begin : response_check
      response_type want;
      if (reset) begin
         high_head = 0;
         high_count = 0;
         low_head = 0;
         low_count = 0;
         threshold_copy = THRESH_RESET;
         expected_responses.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
            threshold_copy = pwdata[THRESH_BITS-1:0];
         end
         if (start && !busy) begin
            expected_responses.push_back(predict_response(req_mode, req_value_in));
         end
         if (rsp_valid) begin
            if (expected_responses.size() == 0) begin
               report_mismatch("response with no transaction pending", rsp_status, 0);
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch("status", rsp_status, want.status);
               end
               if (rsp_value_out !== want.value) begin
                  report_mismatch("value_out", rsp_value_out, want.value);
               end
               status_seen[want.status]++;
               transaction_count++;
            end
         end
      end
   end

   task automatic send_transaction(input logic mode, input logic [VALUE_BITS-1:0] value);
      start <= 1'b1;
      req_mode <= mode;
      req_value_in <= value;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_responses();
      int waited;
      waited = 0;
      start <= 1'b0;
      @(posedge clock);
      while (expected_responses.size() != 0 && waited < 64) begin
         @(posedge clock);
         waited++;
      end
      if (expected_responses.size() != 0) begin
         report_mismatch("responses never arrived", 0, expected_responses.size());
         expected_responses.delete();
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic set_threshold(input logic signed [THRESH_BITS-1:0] threshold);
      logic [CSR_DATA_BITS-1:0] readback;
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_THRESHOLD;
      pwdata <= CSR_DATA_BITS'(threshold);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (readback[THRESH_BITS-1:0] !== threshold) begin
         report_mismatch("threshold readback", readback[THRESH_BITS-1:0], threshold);
      end
      threshold_writes++;
   endtask

   function automatic logic [VALUE_BITS-1:0] pick_value();
      int near;
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2, 3: begin
            near = int'(threshold_copy) + int'($urandom_range(2)) - 1;
            if (near > 32767) near = 32767;
            if (near < -32768) near = -32768;
            return VALUE_BITS'(near);
         end
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   task automatic test_order_and_empty();
      send_transaction(MODE_REMOVE, 16'h1234);
      send_transaction(MODE_INSERT, 16'h7fff);
      send_transaction(MODE_INSERT, 16'h8000);
      send_transaction(MODE_INSERT, 16'd60);
      send_transaction(MODE_INSERT, 16'd61);
      send_transaction(MODE_INSERT, 16'hffff);
      send_transaction(MODE_INSERT, 16'h0000);
      repeat (6) send_transaction(MODE_REMOVE, pick_value());
      send_transaction(MODE_REMOVE, 16'hffff);
      wait_for_responses();
   endtask

   task automatic test_threshold_extremes();
      set_threshold(16'sh7fff);
      send_transaction(MODE_INSERT, 16'h7fff);
      send_transaction(MODE_REMOVE, 16'h0000);
      wait_for_responses();
      set_threshold(-16'sh8000);
      send_transaction(MODE_INSERT, 16'h8000);
      send_transaction(MODE_INSERT, 16'h8001);
      send_transaction(MODE_REMOVE, 16'h5a5a);
      send_transaction(MODE_REMOVE, 16'ha5a5);
      wait_for_responses();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int items);
      int left;
      int burst_len;
      int insert_pct;
      logic mode;
      left = items;
      while (left > 0) begin
         burst_len = $urandom_range(4, 48);
         case ($urandom_range(2))
            0: insert_pct = 90;
            1: insert_pct = 10;
            default: insert_pct = 50;
         endcase
         for (int i = 0; i < burst_len && left > 0; i++) begin
            mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            send_transaction(mode, pick_value());
            left--;
            if ($urandom_range(249) == 0) begin
               wait_for_responses();
            end else begin
               while ($urandom_range(99) < idle_pct) begin
                  start <= 1'b0;
                  @(posedge clock);
               end
            end
         end
      end
      wait_for_responses();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_order_and_empty();
      test_threshold_extremes();
      set_threshold(THRESH_BITS'($urandom));
      test_random_traffic(0, 500);
      set_threshold(-16'sh8000);
      test_random_traffic(82, 500);
      set_threshold(16'sh7fff);
      test_random_traffic(17, 500);
      set_threshold(THRESH_BITS'(int'($urandom_range(400)) - 200));
      test_random_traffic(0, 500);
      repeat (4) @(posedge clock);
      $display("%0d transactions: put high %0d, put low %0d, took high %0d, took low %0d,",
               transaction_count, status_seen[STATUS_PUT_HIGH], status_seen[STATUS_PUT_LOW],
               status_seen[STATUS_TOOK_HIGH], status_seen[STATUS_TOOK_LOW]);
      $display("dropped full %0d, empty %0d; %0d threshold settings, sender idle 0/17/82 pct",
               status_seen[STATUS_FULL], status_seen[STATUS_EMPTY], threshold_writes);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
rtl/tlpq_pkg.sv
rtl/tlpq_ram.sv
rtl/tlpq_fifo.sv
rtl/tlpq_csr.sv
rtl/two_level_priority_queue_unit.sv
test/tb_top.sv
